@@ rtl/ggx_pkg.sv @@
// Package for the two-grain crossfade player: sequencer states, register
// indexes and fixed arithmetic constants. No dependencies.
package ggx_pkg;

    // Sequencer states of the tick datapath.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ATT_MUL,
        ST_ATT_QUO,
        ST_ATT_FRAC,
        ST_POS_GO,
        ST_POS_WAIT,
        ST_PH_GO,
        ST_PH_WAIT,
        ST_W_SEL,
        ST_W_WAIT,
        ST_LATCH,
        ST_IA_GO,
        ST_IA_WAIT,
        ST_RDA,
        ST_IB_GO,
        ST_IB_WAIT,
        ST_RDB,
        ST_MUL,
        ST_SCALE,
        ST_OUT,
        ST_EMIT
    } ggx_state_t;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [2:0] REG_ADVANCE = 3'd0;
    localparam logic [2:0] REG_PITCH   = 3'd1;
    localparam logic [2:0] REG_GRAIN   = 3'd2;
    localparam logic [2:0] REG_BLEND   = 3'd3;
    localparam logic [2:0] REG_VOLUME  = 3'd4;
    localparam logic [2:0] REG_LENGTH  = 3'd5;

    // Reset values of the registers.
    localparam logic signed [19:0] RST_ADVANCE = 20'sd65536;
    localparam logic signed [19:0] RST_PITCH   = 20'sd65536;
    localparam logic [16:0]        RST_GRAIN   = 17'd4800;
    localparam logic [6:0]         RST_BLEND   = 7'd10;
    localparam logic [6:0]         RST_VOLUME  = 7'd40;
    localparam logic [16:0]        RST_LENGTH  = 17'd65536;

    // Percent ceiling, unity weight (Q16) and its number of fraction bits.
    localparam logic [6:0]  PCT_MAX = 7'd100;
    localparam logic [16:0] W_ONE   = 17'h10000;
    localparam int unsigned PCT_DIV = 100;
    localparam int          W_BITS  = 16;

    // Reciprocal of 100 scaled by 2^38; exact for numerators below 2^31.
    localparam logic [31:0] RECIP_100   = 32'd2748779070;
    localparam int          RECIP_SHIFT = 38;

endpackage

@@ rtl/ggx_div.sv @@
// Radix-2 restoring divider giving quotient and remainder, one bit a cycle.
// Uses no package items.
module ggx_div #(
    parameter int W = 50
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quo,
    output logic [W-1:0] rem
);

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     den_reg;

    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             fits;

    // One trial subtraction per cycle.
    always_comb
    begin
        trial = {rem_reg, quo_reg[W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    // Iteration count and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[W-2:0], fits};
            rem_reg <= fits ? diff[W-1:0] : trial[W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/ggx_store.sv @@
// Sample store: one write port and one read port with registered read data.
// Uses no package items.
module ggx_store #(
    parameter int ADDR_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [15:0]       wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [15:0]       rd_data
);

    logic [15:0] mem [1 << ADDR_W];

    // Write on load items; the read port is registered every cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/granular_grain_crossfade_player.sv @@
// Two-grain granular player: sequencer, state registers and config port.
// Depends on ggx_pkg, ggx_div and ggx_store.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in      | into      | in_valid/in_stall  | mode, load_addr, load_value
//  out     | out of    | out_valid/out_stall| sample_out
//  apb     | into      | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// A load item writes the store without holding the input. A tick item takes
// three to five passes of the shared radix-2 divider (position, phase when
// grains run, weight on a ramp, two store indexes) plus the sequencing states.
// Divisions by 100 use a reciprocal multiplication, not the divider.
// Reset sets config and control registers at once; the store is not cleared.
// A finished sample waits in the output register while the next item enters;
// a tick completing while that register is still stalled waits for it.
module granular_grain_crossfade_player #(
    parameter int SAMPLE_ADDR_BITS = 16,
    parameter int FRAC_BITS        = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [15:0]        load_addr,
    input  logic signed [15:0] load_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] sample_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int A     = SAMPLE_ADDR_BITS;
    localparam int F     = FRAC_BITS;
    localparam int PW    = A + F;
    localparam int GW    = 17 + F;
    localparam int PHW   = 18 + F;
    localparam int OBW   = 19 + F;
    localparam int DW    = F + 34;
    localparam int LW    = A + 1;
    localparam int CW    = (LW > 17) ? LW : 17;
    localparam int RA_W  = ((PW > PHW) ? PW : PHW) + 1;
    localparam int RB_W  = ((PW > OBW) ? PW : OBW) + 1;
    localparam int unsigned DEPTH = 1 << A;

    // Configuration registers.
    logic signed [19:0] advance_step_reg;
    logic signed [19:0] pitch_step_reg;
    logic [16:0]        grain_len_reg;
    logic [6:0]         blend_reg;
    logic [6:0]         volume_reg;
    logic [16:0]        sample_length_reg;

    // Player state.
    ggx_pkg::ggx_state_t state_reg, state_next;
    logic [PW-1:0]      pos_reg;
    logic [PHW-1:0]     phase_reg;
    logic [PW-1:0]      start_a_reg;
    logic [PW-1:0]      start_b_reg;

    // Per-tick working registers.
    logic [23:0]        attx_reg;
    logic [16:0]        attq_reg;
    logic [GW-1:0]      att_reg;
    logic [16:0]        w_reg;
    logic [A-1:0]       idx_reg;
    logic signed [15:0] sa_reg;
    logic signed [33:0] prod_a_reg;
    logic signed [33:0] prod_b_reg;
    logic signed [41:0] scaled_reg;
    logic [15:0]        res_reg;
    logic               out_valid_reg;
    logic [15:0]        sample_out_reg;

    // Divider and store connections.
    logic               div_start;
    logic [DW-1:0]      div_num;
    logic [DW-1:0]      div_den;
    logic               div_done;
    logic [DW-1:0]      div_quo;
    logic [DW-1:0]      div_rem;
    logic               st_wr_en;
    logic [A-1:0]       st_wr_addr;
    logic [15:0]        st_rd_data;
    logic [31:0]        addr_ext;

    // Derived values.
    logic               cfg_wr;
    logic               in_acc;
    logic               out_free;
    logic [LW-1:0]      len_eff;
    logic [6:0]         blend_eff;
    logic [6:0]         vol_eff;
    logic [GW-1:0]      g_val;
    logic               g_zero;
    logic [PW:0]        m_pos;
    logic [PHW-1:0]     m_ph;
    logic signed [DW:0] x_pos;
    logic signed [DW:0] x_ph;
    logic [DW-1:0]      pos_mag;
    logic [DW-1:0]      ph_mag;
    logic [PW:0]        pos_rem;
    logic [PHW-1:0]     ph_rem;
    logic [PHW-1:0]     ga_val;
    logic [PHW-1:0]     ga_minus_p;
    logic               p_lt_a;
    logic               p_lt_g;
    logic               p_lt_ga;
    logic               need_div;
    logic [OBW-1:0]     off_b;
    logic [RA_W-1:0]    reader_a;
    logic [RB_W-1:0]    reader_b;
    logic [16:0]        w_comp;
    logic signed [33:0] sum_val;
    logic [41:0]        scaled_mag;
    logic [15:0]        quo_low;
    logic [6:0]         att_rem;
    logic [30:0]        rc_num;
    logic [62:0]        rc_prod;
    logic [24:0]        rc_quo;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_stall = (state_reg != ggx_pkg::ST_IDLE);
    assign in_acc   = in_valid && (state_reg == ggx_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Register file writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            advance_step_reg  <= ggx_pkg::RST_ADVANCE;
            pitch_step_reg    <= ggx_pkg::RST_PITCH;
            grain_len_reg     <= ggx_pkg::RST_GRAIN;
            blend_reg         <= ggx_pkg::RST_BLEND;
            volume_reg        <= ggx_pkg::RST_VOLUME;
            sample_length_reg <= ggx_pkg::RST_LENGTH;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                ggx_pkg::REG_ADVANCE: advance_step_reg  <= signed'(pwdata[19:0]);
                ggx_pkg::REG_PITCH:   pitch_step_reg    <= signed'(pwdata[19:0]);
                ggx_pkg::REG_GRAIN:   grain_len_reg     <= pwdata[16:0];
                ggx_pkg::REG_BLEND:   blend_reg         <= pwdata[6:0];
                ggx_pkg::REG_VOLUME:  volume_reg        <= pwdata[6:0];
                ggx_pkg::REG_LENGTH:  sample_length_reg <= pwdata[16:0];
                default:              ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[4:2])
            ggx_pkg::REG_ADVANCE: prdata = 32'(advance_step_reg);
            ggx_pkg::REG_PITCH:   prdata = 32'(pitch_step_reg);
            ggx_pkg::REG_GRAIN:   prdata = 32'(grain_len_reg);
            ggx_pkg::REG_BLEND:   prdata = 32'(blend_reg);
            ggx_pkg::REG_VOLUME:  prdata = 32'(volume_reg);
            ggx_pkg::REG_LENGTH:  prdata = 32'(sample_length_reg);
            default:              prdata = '0;
        endcase
    end

    // Effective length, blend, volume and grain length.
    always_comb
    begin
        if (sample_length_reg == '0)
        begin
            len_eff = LW'(1);
        end
        else if (CW'(sample_length_reg) > CW'(DEPTH))
        begin
            len_eff = LW'(DEPTH);
        end
        else
        begin
            len_eff = LW'(sample_length_reg);
        end
        blend_eff = (blend_reg > ggx_pkg::PCT_MAX) ? ggx_pkg::PCT_MAX : blend_reg;
        vol_eff   = (volume_reg > ggx_pkg::PCT_MAX) ? ggx_pkg::PCT_MAX : volume_reg;
        g_val     = GW'(grain_len_reg) << F;
        g_zero    = (grain_len_reg == '0);
    end

    // Position and phase wrap operands; the divider yields the remainder.
    always_comb
    begin
        m_pos   = (PW + 1)'(len_eff) << F;
        m_ph    = PHW'(g_val) << 1;
        x_pos   = signed'((DW + 1)'(pos_reg)) + (DW + 1)'(advance_step_reg);
        x_ph    = signed'((DW + 1)'(phase_reg)) + (DW + 1)'(pitch_step_reg);
        pos_mag = x_pos[DW] ? DW'(-x_pos) : DW'(x_pos);
        ph_mag  = x_ph[DW] ? DW'(-x_ph) : DW'(x_ph);
        pos_rem = div_rem[PW:0];
        ph_rem  = div_rem[PHW-1:0];
    end

    // Envelope regions and grain readers.
    always_comb
    begin
        ga_val     = PHW'(g_val) + PHW'(att_reg);
        ga_minus_p = ga_val - phase_reg;
        p_lt_a     = (phase_reg < PHW'(att_reg));
        p_lt_g     = (phase_reg < PHW'(g_val));
        p_lt_ga    = (phase_reg < ga_val);
        need_div   = !g_zero && (p_lt_a || (!p_lt_g && p_lt_ga));
        if (!p_lt_g)
        begin
            off_b = OBW'(phase_reg) - OBW'(g_val);
        end
        else
        begin
            off_b = OBW'(phase_reg) + OBW'(g_val);
        end
        reader_a   = RA_W'(start_a_reg) + RA_W'(phase_reg);
        reader_b   = RB_W'(start_b_reg) + RB_W'(off_b);
        w_comp     = ggx_pkg::W_ONE - w_reg;
        sum_val    = prod_a_reg + prod_b_reg;
        scaled_mag = scaled_reg[41] ? 42'(-scaled_reg) : 42'(scaled_reg);
        quo_low    = rc_quo[15:0];
    end

    // Shared divide-by-100: attack quotient, attack fraction, output scale.
    always_comb
    begin
        att_rem = 7'(attx_reg - 24'(attq_reg) * 24'(ggx_pkg::PCT_DIV));
        unique case (state_reg)
            ggx_pkg::ST_ATT_QUO:  rc_num = 31'(attx_reg);
            ggx_pkg::ST_ATT_FRAC: rc_num = 31'(31'(att_rem) << F);
            default:              rc_num = 31'(scaled_mag >> ggx_pkg::W_BITS);
        endcase
        rc_prod = 63'(rc_num) * 63'(ggx_pkg::RECIP_100);
        rc_quo  = rc_prod[62:ggx_pkg::RECIP_SHIFT];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ggx_pkg::ST_IDLE:
                if (in_acc && mode)
                begin
                    state_next = ggx_pkg::ST_ATT_MUL;
                end
            ggx_pkg::ST_ATT_MUL:  state_next = ggx_pkg::ST_ATT_QUO;
            ggx_pkg::ST_ATT_QUO:  state_next = ggx_pkg::ST_ATT_FRAC;
            ggx_pkg::ST_ATT_FRAC: state_next = ggx_pkg::ST_POS_GO;
            ggx_pkg::ST_POS_GO:   state_next = ggx_pkg::ST_POS_WAIT;
            ggx_pkg::ST_POS_WAIT:
                if (div_done)
                begin
                    state_next = g_zero ? ggx_pkg::ST_W_SEL : ggx_pkg::ST_PH_GO;
                end
            ggx_pkg::ST_PH_GO:    state_next = ggx_pkg::ST_PH_WAIT;
            ggx_pkg::ST_PH_WAIT:
                if (div_done)
                begin
                    state_next = ggx_pkg::ST_W_SEL;
                end
            ggx_pkg::ST_W_SEL:
                state_next = need_div ? ggx_pkg::ST_W_WAIT : ggx_pkg::ST_LATCH;
            ggx_pkg::ST_W_WAIT:
                if (div_done)
                begin
                    state_next = ggx_pkg::ST_LATCH;
                end
            ggx_pkg::ST_LATCH:    state_next = ggx_pkg::ST_IA_GO;
            ggx_pkg::ST_IA_GO:    state_next = ggx_pkg::ST_IA_WAIT;
            ggx_pkg::ST_IA_WAIT:
                if (div_done)
                begin
                    state_next = ggx_pkg::ST_RDA;
                end
            ggx_pkg::ST_RDA:      state_next = ggx_pkg::ST_IB_GO;
            ggx_pkg::ST_IB_GO:    state_next = ggx_pkg::ST_IB_WAIT;
            ggx_pkg::ST_IB_WAIT:
                if (div_done)
                begin
                    state_next = ggx_pkg::ST_RDB;
                end
            ggx_pkg::ST_RDB:      state_next = ggx_pkg::ST_MUL;
            ggx_pkg::ST_MUL:      state_next = ggx_pkg::ST_SCALE;
            ggx_pkg::ST_SCALE:    state_next = ggx_pkg::ST_OUT;
            ggx_pkg::ST_OUT:      state_next = ggx_pkg::ST_EMIT;
            ggx_pkg::ST_EMIT:
                if (out_free)
                begin
                    state_next = ggx_pkg::ST_IDLE;
                end
            default:              state_next = ggx_pkg::ST_IDLE;
        endcase
    end

    // Divider requests per state.
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            ggx_pkg::ST_POS_GO:
            begin
                div_start = 1'b1;
                div_num   = pos_mag;
                div_den   = DW'(m_pos);
            end
            ggx_pkg::ST_PH_GO:
            begin
                div_start = 1'b1;
                div_num   = ph_mag;
                div_den   = DW'(m_ph);
            end
            ggx_pkg::ST_W_SEL:
            begin
                div_start = need_div;
                div_num   = p_lt_a ? {phase_reg, 16'b0} : {ga_minus_p, 16'b0};
                div_den   = DW'(att_reg);
            end
            ggx_pkg::ST_IA_GO:
            begin
                div_start = 1'b1;
                div_num   = DW'(reader_a >> F);
                div_den   = DW'(len_eff);
            end
            ggx_pkg::ST_IB_GO:
            begin
                div_start = 1'b1;
                div_num   = DW'(reader_b >> F);
                div_den   = DW'(len_eff);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Control state: sequencer, position, phase, grain starts, output flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ggx_pkg::ST_IDLE;
            pos_reg       <= '0;
            phase_reg     <= '0;
            start_a_reg   <= '0;
            start_b_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ggx_pkg::ST_POS_WAIT && div_done)
            begin
                if (x_pos[DW] && pos_rem != '0)
                begin
                    pos_reg <= PW'(m_pos - pos_rem);
                end
                else
                begin
                    pos_reg <= PW'(pos_rem);
                end
                if (g_zero)
                begin
                    phase_reg <= '0;
                end
            end
            if (state_reg == ggx_pkg::ST_PH_WAIT && div_done)
            begin
                if (x_ph[DW] && ph_rem != '0)
                begin
                    phase_reg <= m_ph - ph_rem;
                end
                else
                begin
                    phase_reg <= ph_rem;
                end
            end
            if (state_reg == ggx_pkg::ST_LATCH)
            begin
                if (w_reg == '0)
                begin
                    start_a_reg <= pos_reg;
                end
                else if (w_reg == ggx_pkg::W_ONE)
                begin
                    start_b_reg <= pos_reg;
                end
            end
            if (state_reg == ggx_pkg::ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of one tick.
    always_ff @(posedge clk)
    begin
        // The attack is grain * blend / 100, split into whole and fraction.
        if (state_reg == ggx_pkg::ST_ATT_MUL)
        begin
            attx_reg <= 24'(grain_len_reg) * 24'(blend_eff);
        end
        if (state_reg == ggx_pkg::ST_ATT_QUO)
        begin
            attq_reg <= rc_quo[16:0];
        end
        if (state_reg == ggx_pkg::ST_ATT_FRAC)
        begin
            att_reg <= (GW'(attq_reg) << F) + GW'(rc_quo);
        end
        if (state_reg == ggx_pkg::ST_W_SEL && !need_div)
        begin
            w_reg <= (!g_zero && p_lt_g) ? ggx_pkg::W_ONE : '0;
        end
        if (state_reg == ggx_pkg::ST_W_WAIT && div_done)
        begin
            w_reg <= div_quo[16:0];
        end
        if ((state_reg == ggx_pkg::ST_IA_WAIT || state_reg == ggx_pkg::ST_IB_WAIT)
            && div_done)
        begin
            idx_reg <= div_rem[A-1:0];
        end
        if (state_reg == ggx_pkg::ST_IB_GO)
        begin
            sa_reg <= signed'(st_rd_data);
        end
        if (state_reg == ggx_pkg::ST_MUL)
        begin
            prod_a_reg <= 34'(sa_reg) * 34'(signed'({1'b0, w_reg}));
            prod_b_reg <= 34'(signed'(st_rd_data)) * 34'(signed'({1'b0, w_comp}));
        end
        if (state_reg == ggx_pkg::ST_SCALE)
        begin
            scaled_reg <= 42'(sum_val) * 42'(signed'({1'b0, vol_eff}));
        end
        // Truncation toward zero: divide the magnitude, then restore the sign.
        if (state_reg == ggx_pkg::ST_OUT)
        begin
            res_reg <= scaled_reg[41] ? (16'd0 - quo_low) : quo_low;
        end
        if (state_reg == ggx_pkg::ST_EMIT && out_free)
        begin
            sample_out_reg <= res_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = signed'(sample_out_reg);

    // Store write from load items.
    assign addr_ext   = 32'(load_addr);
    assign st_wr_en   = in_acc && !mode;
    assign st_wr_addr = addr_ext[A-1:0];

    ggx_div #(
        .W (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    ggx_store #(
        .ADDR_W (A)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (load_value),
        .rd_addr (idx_reg),
        .rd_data (st_rd_data)
    );

endmodule

@@ rtl/ggx_checker.sv @@
// Port-level checks for the crossfade player, bound to the top level.
// Depends only on the top level's ports.
module ggx_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               mode,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] sample_out
);

    // A stalled output item holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out))
        else $error("output item changed while stalled");

    // A tick item occupies the block for at least the next cycle.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode |=> in_stall)
        else $error("tick item did not occupy the block");

    // A load item completes in its own cycle.
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !mode |=> !in_stall)
        else $error("load item held the input");

    // An output item only appears at the end of a tick's work.
    a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("output item without a tick in progress");

endmodule

bind granular_grain_crossfade_player ggx_checker u_ggx_checker (.*);
